>>> rtl/srs_pkg.sv
// Shared types and constants for the selective repeat sender.
`timescale 1ns / 1ps

package srs_pkg;

    // Fixed field widths
    localparam int SEQ_W = 16;
    localparam int PKT_W = 16;
    localparam int WIN_W = 7;
    localparam int CNT_W = 32;
    localparam int CFG_W = 16;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2
    } t_cmd;

    // Configuration register indexes
    localparam logic CFG_PACKET_TOTAL = 1'b0;
    localparam logic CFG_WINDOW_LIMIT = 1'b1;

endpackage

>>> rtl/srs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module srs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/selective_repeat_sender_top.sv
// Selective repeat ARQ sender: window control, acknowledge marks and send orders.
//
// Input channel (i_in_valid / o_in_stall) carries one command beat: start, ack
// with its sequence number, or retransmission timeout. Output channel
// (o_out_valid / i_out_stall) carries result beats: one per transmission
// order, or a single status beat when a command orders none; the final beat
// of a command has o_out_last set. Every beat carries the window base, the
// done flag and both counters as they stand after the whole command.
// Acknowledge marks live in a MAX_WINDOW x 1 RAM with registered read data.
// Start plans and counts, then sends the new sequence numbers (one per cycle
// while the output is not stalled). Ack marks its slot, slides the base (one
// RAM read-check pair per slot it slides), then plans, counts and sends.
// Timeout runs the counting scan over the outstanding slots, then the resend
// pass (read, then check, per outstanding slot). An unknown command gives
// a single status beat.
// The next command is taken while the final beat still waits in the output
// register. A stall on the output freezes the sequencer at its next beat.
// Reset clears window, counters and packet total at once, sets the window limit
// to one; the RAM needs no clearing since each slot is written on first send.
`timescale 1ns / 1ps

module selective_repeat_sender_top
    import srs_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int SEQ_BITS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_in_command,
    input  logic [SEQ_W-1:0] i_in_ack_seq,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_out_send_valid,
    output logic [SEQ_W-1:0] o_out_send_seq,
    output logic             o_out_is_retransmit,
    output logic             o_out_last,
    output logic [SEQ_W-1:0] o_out_window_base,
    output logic             o_out_transfer_done,
    output logic             o_out_ack_ignored,
    output logic [CNT_W-1:0] o_out_sends_total,
    output logic [CNT_W-1:0] o_out_resends_total
);

    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int MASK_BITS = (SEQ_BITS < SEQ_W) ? SEQ_BITS : SEQ_W;
    localparam logic [SEQ_W-1:0] SEQ_MASK = SEQ_W'((17'd1 << MASK_BITS) - 17'd1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);
    localparam logic [SLOT_W:0]   SLOT_SPAN = (SLOT_W + 1)'(MAX_WINDOW);
    localparam logic [WIN_W-1:0]  WIN_MAX   = WIN_W'(MAX_WINDOW);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK,
        ST_SL_RD,
        ST_SL_CHK,
        ST_PLAN,
        ST_COUNT,
        ST_SEND,
        ST_SCAN,
        ST_RS_RD,
        ST_RS_CHK,
        ST_STATUS
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [SEQ_W-1:0]    r_ack;
    logic                r_ignored;

    logic [PKT_W-1:0]    r_pkt_total;
    logic [WIN_W-1:0]    r_win_limit;

    logic [SEQ_W-1:0]    r_base;
    logic [SEQ_W-1:0]    r_next;
    logic [SLOT_W-1:0]   r_base_slot;
    logic [SLOT_W-1:0]   r_next_slot;
    logic [CNT_W-1:0]    r_send_cnt;
    logic [CNT_W-1:0]    r_resend_cnt;

    logic [WIN_W-1:0]    r_n;
    logic [SEQ_W-1:0]    r_scan_seq;
    logic [SLOT_W-1:0]   r_scan_slot;
    logic                r_rd_pend;

    logic                r_out_valid;
    logic                r_out_send_valid;
    logic [SEQ_W-1:0]    r_out_send_seq;
    logic                r_out_is_retx;
    logic                r_out_last;
    logic [SEQ_W-1:0]    r_out_base;
    logic                r_out_done;
    logic                r_out_ignored;
    logic [CNT_W-1:0]    r_out_sends;
    logic [CNT_W-1:0]    r_out_resends;

    logic                in_accept;
    logic                out_free;
    logic [WIN_W-1:0]    eff_win;
    logic                ack_in_range;
    logic [SEQ_W-1:0]    ack_off;
    logic [SLOT_W:0]     ack_sum;
    logic [SLOT_W-1:0]   ack_slot;
    logic [SEQ_W:0]      lim_win;
    logic [SEQ_W:0]      lim;
    logic [SEQ_W:0]      refill_n;
    logic [CNT_W:0]      send_sum;
    logic [CNT_W:0]      resend_sum;
    logic                scan_more;

    logic                ram_wr_en;
    logic [SLOT_W-1:0]   ram_wr_addr;
    logic [0:0]          ram_wr_data;
    logic                ram_rd_en;
    logic [SLOT_W-1:0]   ram_rd_addr;
    logic [0:0]          ram_rd_data;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Clamp the window limit into 1..MAX_WINDOW
    always_comb begin
        if (r_win_limit == '0) begin
            eff_win = WIN_W'(1);
        end else if (r_win_limit > WIN_MAX) begin
            eff_win = WIN_MAX;
        end else begin
            eff_win = r_win_limit;
        end
    end

    // Locate the slot of an acknowledged number relative to the base slot
    assign ack_in_range = (r_ack >= r_base) && (r_ack < r_next);
    assign ack_off      = r_ack - r_base;
    assign ack_sum      = (SLOT_W + 1)'(r_base_slot) + (SLOT_W + 1)'(ack_off[SLOT_W-1:0]);
    assign ack_slot     = (ack_sum >= SLOT_SPAN) ? SLOT_W'(ack_sum - SLOT_SPAN)
                                                 : ack_sum[SLOT_W-1:0];

    // New numbers that fit the window and the run length
    assign lim_win  = {1'b0, r_base} + (SEQ_W + 1)'(eff_win);
    assign lim      = (lim_win < {1'b0, r_pkt_total}) ? lim_win : {1'b0, r_pkt_total};
    assign refill_n = (lim > {1'b0, r_next}) ? lim - {1'b0, r_next} : '0;

    // Saturating counter sums for the whole command
    assign send_sum   = {1'b0, r_send_cnt} + (CNT_W + 1)'(r_n);
    assign resend_sum = {1'b0, r_resend_cnt} + (CNT_W + 1)'(r_n);

    assign scan_more = r_scan_seq < r_next;

    // RAM port steering
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_next_slot;
        ram_wr_data = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_scan_slot;
        case (r_state)
            ST_ACK: begin
                ram_wr_en   = ack_in_range;
                ram_wr_addr = ack_slot;
                ram_wr_data = 1'b1;
            end
            ST_SEND: begin
                ram_wr_en   = out_free;
                ram_wr_addr = r_next_slot;
                ram_wr_data = 1'b0;
            end
            ST_SL_RD: begin
                ram_rd_en   = r_base < r_next;
                ram_rd_addr = r_base_slot;
            end
            ST_SCAN: begin
                ram_rd_en   = scan_more;
                ram_rd_addr = r_scan_slot;
            end
            ST_RS_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_scan_slot;
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    srs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WINDOW)
    ) u_marks (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_total <= '0;
            r_win_limit <= WIN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PACKET_TOTAL: r_pkt_total <= i_cfg_data[PKT_W-1:0];
                CFG_WINDOW_LIMIT: r_win_limit <= i_cfg_data[WIN_W-1:0];
                default:          r_win_limit <= r_win_limit;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_base       <= '0;
            r_next       <= '0;
            r_base_slot  <= '0;
            r_next_slot  <= '0;
            r_send_cnt   <= '0;
            r_resend_cnt <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // drop the beat once taken
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_cmd       <= t_cmd'(i_in_command);
                        r_ack       <= i_in_ack_seq;
                        r_ignored   <= 1'b0;
                        r_scan_seq  <= r_base;
                        r_scan_slot <= r_base_slot;
                        r_rd_pend   <= 1'b0;
                        r_n         <= '0;
                        case (i_in_command)
                            CMD_START: begin
                                r_base       <= '0;
                                r_next       <= '0;
                                r_base_slot  <= '0;
                                r_next_slot  <= '0;
                                r_send_cnt   <= '0;
                                r_resend_cnt <= '0;
                                r_state      <= ST_PLAN;
                            end
                            CMD_ACK:     r_state <= ST_ACK;
                            CMD_TIMEOUT: r_state <= ST_SCAN;
                            default:     r_state <= ST_STATUS;
                        endcase
                    end
                end

                // mark the acknowledged slot, or flag a stray ack
                ST_ACK: begin
                    r_ignored <= !ack_in_range;
                    r_state   <= ST_SL_RD;
                end

                // slide the base past acknowledged slots
                ST_SL_RD: begin
                    r_state <= (r_base < r_next) ? ST_SL_CHK : ST_PLAN;
                end

                ST_SL_CHK: begin
                    if (ram_rd_data[0]) begin
                        r_base      <= r_base + 1'b1;
                        r_base_slot <= slot_inc(r_base_slot);
                        r_state     <= ST_SL_RD;
                    end else begin
                        r_state <= ST_PLAN;
                    end
                end

                ST_PLAN: begin
                    r_n     <= refill_n[WIN_W-1:0];
                    r_state <= ST_COUNT;
                end

                // count unacknowledged slots, one read issued per cycle
                ST_SCAN: begin
                    if (scan_more) begin
                        r_scan_seq  <= r_scan_seq + 1'b1;
                        r_scan_slot <= slot_inc(r_scan_slot);
                    end
                    r_rd_pend <= scan_more;
                    if (r_rd_pend && !ram_rd_data[0]) begin
                        r_n <= r_n + 1'b1;
                    end
                    if (!scan_more && !r_rd_pend) begin
                        r_state <= ST_COUNT;
                    end
                end

                // settle the counters for the whole command
                ST_COUNT: begin
                    r_send_cnt <= send_sum[CNT_W] ? '1 : send_sum[CNT_W-1:0];
                    if (r_cmd == CMD_TIMEOUT) begin
                        r_resend_cnt <= resend_sum[CNT_W] ? '1 : resend_sum[CNT_W-1:0];
                    end
                    r_scan_seq  <= r_base;
                    r_scan_slot <= r_base_slot;
                    if (r_n == '0) begin
                        r_state <= ST_STATUS;
                    end else if (r_cmd == CMD_TIMEOUT) begin
                        r_state <= ST_RS_RD;
                    end else begin
                        r_state <= ST_SEND;
                    end
                end

                // order new numbers, one beat a cycle while the output is not stalled
                ST_SEND: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out_send_valid <= 1'b1;
                        r_out_send_seq   <= r_next & SEQ_MASK;
                        r_out_is_retx    <= 1'b0;
                        r_out_last       <= (r_n == WIN_W'(1));
                        r_out_base       <= r_base & SEQ_MASK;
                        r_out_done       <= r_base >= r_pkt_total;
                        r_out_ignored    <= r_ignored;
                        r_out_sends      <= r_send_cnt;
                        r_out_resends    <= r_resend_cnt;
                        r_next           <= r_next + 1'b1;
                        r_next_slot      <= slot_inc(r_next_slot);
                        r_n              <= r_n - 1'b1;
                        if (r_n == WIN_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end

                ST_RS_RD: begin
                    r_state <= ST_RS_CHK;
                end

                // resend unacknowledged slots; skip marked ones
                ST_RS_CHK: begin
                    if (ram_rd_data[0]) begin
                        r_scan_seq  <= r_scan_seq + 1'b1;
                        r_scan_slot <= slot_inc(r_scan_slot);
                        r_state     <= ST_RS_RD;
                    end else if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out_send_valid <= 1'b1;
                        r_out_send_seq   <= r_scan_seq & SEQ_MASK;
                        r_out_is_retx    <= 1'b1;
                        r_out_last       <= (r_n == WIN_W'(1));
                        r_out_base       <= r_base & SEQ_MASK;
                        r_out_done       <= r_base >= r_pkt_total;
                        r_out_ignored    <= r_ignored;
                        r_out_sends      <= r_send_cnt;
                        r_out_resends    <= r_resend_cnt;
                        r_scan_seq       <= r_scan_seq + 1'b1;
                        r_scan_slot      <= slot_inc(r_scan_slot);
                        r_n              <= r_n - 1'b1;
                        r_state          <= (r_n == WIN_W'(1)) ? ST_IDLE : ST_RS_RD;
                    end
                end

                // single status beat when nothing is ordered
                ST_STATUS: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out_send_valid <= 1'b0;
                        r_out_send_seq   <= '0;
                        r_out_is_retx    <= 1'b0;
                        r_out_last       <= 1'b1;
                        r_out_base       <= r_base & SEQ_MASK;
                        r_out_done       <= r_base >= r_pkt_total;
                        r_out_ignored    <= r_ignored;
                        r_out_sends      <= r_send_cnt;
                        r_out_resends    <= r_resend_cnt;
                        r_state          <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall          = (r_state != ST_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_out_send_valid    = r_out_send_valid;
    assign o_out_send_seq      = r_out_send_seq;
    assign o_out_is_retransmit = r_out_is_retx;
    assign o_out_last          = r_out_last;
    assign o_out_window_base   = r_out_base;
    assign o_out_transfer_done = r_out_done;
    assign o_out_ack_ignored   = r_out_ignored;
    assign o_out_sends_total   = r_out_sends;
    assign o_out_resends_total = r_out_resends;

`ifndef SYNTHESIS
    // outstanding span never exceeds the mark RAM
    a_window_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next >= r_base) && ((r_next - r_base) <= SEQ_W'(MAX_WINDOW)))
        else $error("outstanding window exceeds mark storage");

    // a status beat always closes its command
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_send_valid) |-> (o_out_last && !o_out_is_retransmit))
        else $error("status beat without last or with retransmit flag");

    // an accepted command keeps the input stalled in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a command");

    // resend counter never runs ahead of the send counter
    a_counter_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resend_cnt <= r_send_cnt)
        else $error("resend count exceeds send count");
`endif

endmodule

>>> bench/selective_repeat_sender_top_test.sv
// Self-checking bench for the selective repeat sender: directed table, random runs, scoreboard.
`timescale 1ns / 1ps

module selective_repeat_sender_top_test;
    import srs_pkg::*;

    localparam int MAX_WIN = 64;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int IDLE_PCT = 13;

    // One result beat as seen on the output channel
    typedef struct packed {
        logic             send_valid;
        logic [SEQ_W-1:0] send_seq;
        logic             retx;
        logic             last;
        logic [SEQ_W-1:0] base;
        logic             done;
        logic             ignored;
        logic [CNT_W-1:0] sends;
        logic [CNT_W-1:0] resends;
    } t_sr_beat;

    typedef enum logic {ROW_CMD, ROW_REG} t_row_kind;

    // One row of the directed table: a command beat or a register write
    typedef struct {
        t_row_kind        kind;
        logic [1:0]       code;
        logic [SEQ_W-1:0] data;
        bit               typed;
        logic             done;
        logic             ignored;
    } t_plan_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [1:0]       i_in_command = CMD_START;
    logic [SEQ_W-1:0] i_in_ack_seq = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_out_send_valid;
    logic [SEQ_W-1:0] o_out_send_seq;
    logic             o_out_is_retransmit;
    logic             o_out_last;
    logic [SEQ_W-1:0] o_out_window_base;
    logic             o_out_transfer_done;
    logic             o_out_ack_ignored;
    logic [CNT_W-1:0] o_out_sends_total;
    logic [CNT_W-1:0] o_out_resends_total;

    // Window predictor state and its copy of the registers
    int unsigned      sn_base;
    int unsigned      sn_next;
    bit               acked [MAX_WIN];
    logic [CNT_W-1:0] n_sends;
    logic [CNT_W-1:0] n_resends;
    int unsigned      cfg_packets;
    int unsigned      cfg_window;

    t_sr_beat  step_beats[$];
    t_sr_beat  expected_beats[$];
    t_plan_row plan[$];
    int        mismatches = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;
    bit        hold_off = 1'b0;

    selective_repeat_sender_top #(
        .MAX_WINDOW (MAX_WIN),
        .SEQ_BITS   (SEQ_W)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_command        (i_in_command),
        .i_in_ack_seq        (i_in_ack_seq),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_send_valid    (o_out_send_valid),
        .o_out_send_seq      (o_out_send_seq),
        .o_out_is_retransmit (o_out_is_retransmit),
        .o_out_last          (o_out_last),
        .o_out_window_base   (o_out_window_base),
        .o_out_transfer_done (o_out_transfer_done),
        .o_out_ack_ignored   (o_out_ack_ignored),
        .o_out_sends_total   (o_out_sends_total),
        .o_out_resends_total (o_out_resends_total)
    );

    always #5 i_clk = ~i_clk;

    // Print one line per mismatch (first few only) and count every one
    task automatic report_mismatch(input string field, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch on %s: got %0h, want %0h (t=%0t)", field, got, want, $time);
        end
    endtask

    // Record one transmission order and bump the saturating counters
    task automatic order_send(input int unsigned seq, input bit retx);
        t_sr_beat b;
        b = '0;
        b.send_valid = 1'b1;
        b.send_seq = seq[SEQ_W-1:0];
        b.retx = retx;
        step_beats.push_back(b);
        if (n_sends != '1) n_sends++;
        if (retx && n_resends != '1) n_resends++;
    endtask

    // Send new numbers until the window or the run is full
    task automatic refill(input int unsigned w);
        while (step_beats.size() < MAX_WIN && sn_next < sn_base + w && sn_next < cfg_packets) begin
            order_send(sn_next, 1'b0);
            sn_next++;
        end
    endtask

    // Work out the beats that one command causes, leaving them in step_beats
    task automatic predict_command(input logic [1:0] cmd, input logic [SEQ_W-1:0] ack);
        bit          ignored;
        int unsigned w;
        int unsigned s;
        t_sr_beat    b;
        step_beats.delete();
        ignored = 1'b0;
        w = (cfg_window == 0) ? 1 : (cfg_window > MAX_WIN) ? MAX_WIN : cfg_window;
        case (cmd)
            CMD_START: begin
                foreach (acked[i]) acked[i] = 1'b0;
                sn_base = 0;
                sn_next = 0;
                n_sends = '0;
                n_resends = '0;
                refill(w);
            end
            CMD_ACK: begin
                if (ack >= sn_base && ack < sn_next) acked[ack % MAX_WIN] = 1'b1;
                else ignored = 1'b1;
                // slide past the acknowledged left edge
                while (sn_base < sn_next && acked[sn_base % MAX_WIN]) begin
                    acked[sn_base % MAX_WIN] = 1'b0;
                    sn_base++;
                end
                refill(w);
            end
            CMD_TIMEOUT: begin
                for (s = sn_base; s < sn_next && step_beats.size() < MAX_WIN; s++) begin
                    if (!acked[s % MAX_WIN]) order_send(s, 1'b1);
                end
            end
            default: begin
            end
        endcase
        if (step_beats.size() == 0) begin
            b = '0;
            step_beats.push_back(b);
        end
        foreach (step_beats[i]) begin
            step_beats[i].last = (i == step_beats.size() - 1);
            step_beats[i].base = sn_base[SEQ_W-1:0];
            step_beats[i].done = (sn_base >= cfg_packets);
            step_beats[i].ignored = ignored;
            step_beats[i].sends = n_sends;
            step_beats[i].resends = n_resends;
        end
    endtask

    // Offer one command beat, hold it until taken, then queue what it should cause
    task automatic offer(input logic [1:0] cmd, input logic [SEQ_W-1:0] ack, input bit typed,
                         input t_sr_beat fixed);
        int gap;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_command <= cmd;
        i_in_ack_seq <= ack;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_command(cmd, ack);
        if (typed) begin
            expected_beats.push_back(fixed);
        end else begin
            foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
        end
    endtask

    // Drop valid and wait until every expected beat has come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PACKET_TOTAL) cfg_packets = val;
        else cfg_window = val[WIN_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic add_row(input t_row_kind kind, input logic [1:0] code,
                           input logic [SEQ_W-1:0] data, input bit typed,
                           input logic done, input logic ignored);
        t_plan_row row;
        row.kind = kind;
        row.code = code;
        row.data = data;
        row.typed = typed;
        row.done = done;
        row.ignored = ignored;
        plan.push_back(row);
    endtask

    // Compare one accepted result beat against the oldest expectation
    task automatic check_beat();
        t_sr_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected", o_out_send_seq, 0);
        end else begin
            want = expected_beats.pop_front();
            if (o_out_send_valid !== want.send_valid)
                report_mismatch("send_valid", o_out_send_valid, want.send_valid);
            if (o_out_send_seq !== want.send_seq)
                report_mismatch("send_seq", o_out_send_seq, want.send_seq);
            if (o_out_is_retransmit !== want.retx)
                report_mismatch("is_retransmit", o_out_is_retransmit, want.retx);
            if (o_out_last !== want.last)
                report_mismatch("last", o_out_last, want.last);
            if (o_out_window_base !== want.base)
                report_mismatch("window_base", o_out_window_base, want.base);
            if (o_out_transfer_done !== want.done)
                report_mismatch("transfer_done", o_out_transfer_done, want.done);
            if (o_out_ack_ignored !== want.ignored)
                report_mismatch("ack_ignored", o_out_ack_ignored, want.ignored);
            if (o_out_sends_total !== want.sends)
                report_mismatch("sends_total", o_out_sends_total, want.sends);
            if (o_out_resends_total !== want.resends)
                report_mismatch("resends_total", o_out_resends_total, want.resends);
        end
    endtask

    // Receiver: check taken beats, stall at random or during the hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_beat();
        i_out_stall <= hold_off || (!calm && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Long receiver hold-off so that the block fills and stalls its input
    initial begin : receiver_hold
        wait (hold_req);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        t_plan_row        row;
        t_sr_beat         fixed;
        t_sr_beat         no_beat;
        logic [SEQ_W-1:0] phase_packets [7];
        logic [CFG_W-1:0] phase_windows [7];
        logic [SEQ_W-1:0] a;
        int               ph;
        int               k;
        int               r;
        int               n;

        no_beat = '0;
        sn_base = 0;
        sn_next = 0;
        foreach (acked[i]) acked[i] = 1'b0;
        n_sends = '0;
        n_resends = '0;
        cfg_packets = 0;
        cfg_window = 1;

        // Straight after reset: status beats with nothing outstanding
        add_row(ROW_CMD, CMD_ACK, 16'h0000, 1, 1, 1);
        add_row(ROW_CMD, CMD_TIMEOUT, 16'h0000, 1, 1, 0);
        add_row(ROW_CMD, CMD_UNKNOWN, 16'hFFFF, 1, 1, 0);
        add_row(ROW_CMD, CMD_START, 16'hA5A5, 1, 1, 0);
        // Window of zero acts as one; duplicate ack and a lone resend
        add_row(ROW_REG, CFG_PACKET_TOTAL, 16'd5, 0, 0, 0);
        add_row(ROW_REG, CFG_WINDOW_LIMIT, 16'd0, 0, 0, 0);
        add_row(ROW_CMD, CMD_START, 16'h0000, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd0, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd0, 0, 0, 0);
        add_row(ROW_CMD, CMD_TIMEOUT, 16'h0000, 0, 0, 0);
        // Oversized window clamps; out-of-order acks, then the run completes
        add_row(ROW_REG, CFG_WINDOW_LIMIT, 16'd127, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd1, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd3, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd4, 0, 0, 0);
        add_row(ROW_CMD, CMD_TIMEOUT, 16'h0000, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd2, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'hFFFF, 0, 0, 0);
        // Largest run and full window: full burst, full resend, edge slide
        add_row(ROW_REG, CFG_PACKET_TOTAL, 16'hFFFF, 0, 0, 0);
        add_row(ROW_REG, CFG_WINDOW_LIMIT, 16'd64, 0, 0, 0);
        add_row(ROW_CMD, CMD_START, 16'h0000, 0, 0, 0);
        add_row(ROW_CMD, CMD_TIMEOUT, 16'h0000, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd63, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd0, 0, 0, 0);
        add_row(ROW_CMD, CMD_TIMEOUT, 16'h0000, 0, 0, 0);
        add_row(ROW_CMD, CMD_UNKNOWN, 16'h5A5A, 0, 0, 0);
        // Upper data bits beyond the window register are dropped
        add_row(ROW_REG, CFG_WINDOW_LIMIT, 16'hFF83, 0, 0, 0);
        add_row(ROW_CMD, CMD_START, 16'h0000, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd1, 0, 0, 0);
        add_row(ROW_CMD, CMD_ACK, 16'd0, 0, 0, 0);

        phase_packets = '{16'd12, 16'd40, 16'd300, 16'd3, 16'hFFFF, 16'd150, 16'd1};
        phase_windows = '{16'd4, 16'd64, 16'd127, 16'd0, 16'd64, 16'd9, 16'd2};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_REG) begin
                settle();
                write_reg(row.code[0], row.data);
            end else begin
                fixed = '0;
                fixed.last = 1'b1;
                fixed.done = row.done;
                fixed.ignored = row.ignored;
                offer(row.code, row.data, row.typed, fixed);
            end
        end

        // Random runs, one register setting per phase
        for (ph = 0; ph < 7; ph++) begin
            settle();
            write_reg(CFG_PACKET_TOTAL, phase_packets[ph]);
            write_reg(CFG_WINDOW_LIMIT, phase_windows[ph]);
            calm <= (ph == 2);
            offer(CMD_START, $urandom, 0, no_beat);
            for (k = 0; k < 60; k++) begin
                if (ph == 4 && k == 10) hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (sn_base >= cfg_packets || r < 3) begin
                    offer(CMD_START, $urandom, 0, no_beat);
                end else if (r < 11) begin
                    offer(CMD_TIMEOUT, $urandom, 0, no_beat);
                end else if (r < 15) begin
                    offer(CMD_UNKNOWN, $urandom, 0, no_beat);
                end else if (r < 22) begin
                    offer(CMD_ACK, $urandom_range(0, 65535), 0, no_beat);
                end else if (r < 26) begin
                    // just past either end of the outstanding range
                    a = (sn_base > 0 && $urandom_range(0, 1)) ? sn_base - 1 : sn_next;
                    offer(CMD_ACK, a, 0, no_beat);
                end else begin
                    // well-formed ack, biased to the left edge so the window slides
                    if (sn_next == sn_base || $urandom_range(0, 1)) a = sn_base;
                    else a = sn_base + $urandom_range(0, sn_next - sn_base - 1);
                    offer(CMD_ACK, a, 0, no_beat);
                end
            end
        end

        // Drain, then give the block time to show any stray beat
        i_in_valid <= 1'b0;
        calm <= 1'b0;
        for (n = 0; n < 20000 && expected_beats.size() != 0; n++) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (expected_beats.size() != 0)
            report_mismatch("results never delivered", expected_beats.size(), 0);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : run_limit
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
